// File: hdl/ipl_pkg.sv
// ----------------------------------------------------------------------------
// ipl_pkg: indoor path loss shared definitions
// Field widths, fixed-point constants and control types used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package ipl_pkg;

    localparam int PAIRS_DEF       = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int DIST_W    = 16;
    localparam int PAIR_W    = 8;
    localparam int FRESH_W   = 16;
    localparam int LOSS_W    = 12;
    localparam int CARRIER_W = 13;
    localparam int PAIR_SPAN = 1 << PAIR_W;

    localparam int MUL_W     = 33;
    localparam int PROD_W    = 64;
    localparam int LOG_ARG_W = 32;
    localparam int LOG_W     = 21;
    localparam int DLOG_W    = 22;
    localparam int STEP_W    = 4;

    localparam logic [CARRIER_W-1:0] CARRIER_RESET = 13'd763;
    localparam logic [CARRIER_W-1:0] FREQ_LO       = 13'd758;
    localparam logic [CARRIER_W-1:0] FREQ_HI       = 13'd798;

    localparam logic [LOG_ARG_W-1:0] REF_DIST = 32'd16000;
    localparam logic [LOG_W-1:0]     LOG_INIT = 21'd2031616;
    localparam logic [STEP_W-1:0]    SQ_FIRST = 4'd15;
    localparam logic [STEP_W-1:0]    NORM_LAST = 4'd4;
    // L2(16000) - L2(2000): same mantissa, three octaves
    localparam logic signed [DLOG_W-1:0] OCTAVE3 = 22'sd196608;

    localparam logic [DIST_W-1:0] LOS_NEAR = 16'd288;
    localparam logic [DIST_W-1:0] LOS_FAR  = 16'd592;

    localparam logic signed [MUL_W-1:0] LOG10_2_Q32 = 33'sd1292913986;
    localparam logic signed [MUL_W-1:0] LOG2E_Q16   = 33'sd94548;
    localparam logic signed [MUL_W-1:0] LOS_SLOPE   = 33'sd432;
    localparam logic signed [MUL_W-1:0] FREQ_SCALE  = 33'sd200;
    localparam logic signed [MUL_W-1:0] RECIP5      = 33'sd52429;

    localparam logic signed [MUL_W-1:0] B_LOS  = 33'sd169;
    localparam logic signed [MUL_W-1:0] B_NLOS = 33'sd433;
    localparam logic signed [MUL_W-1:0] B_DB1  = 33'sd428;
    localparam logic signed [MUL_W-1:0] B_DB2  = 33'sd433;

    localparam logic signed [PROD_W-1:0] A_LOS  = 64'sd895 <<< 48;
    localparam logic signed [PROD_W-1:0] A_NLOS = 64'sd1475 <<< 48;
    localparam logic signed [PROD_W-1:0] A_DB1  = 64'sd1311 <<< 48;
    localparam logic signed [PROD_W-1:0] A_DB2  = 64'sd1474 <<< 48;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd5 <<< 44;

    localparam logic [15:0] LOSS_MAX = 16'd4095;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } cache_ctl_t;

endpackage

`default_nettype wire

// File: hdl/ipl_ifs.sv
// ----------------------------------------------------------------------------
// ipl_ifs: indoor path loss channel interfaces
// Valid/ready channels for link items, results and the carrier register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipl_link_if;
    logic                          valid;
    logic                          ready;
    logic [ipl_pkg::DIST_W-1:0]    distance;
    logic                          same_building;
    logic [ipl_pkg::PAIR_W-1:0]    pair_id;
    logic [ipl_pkg::FRESH_W-1:0]   fresh_sample;

    modport source (output valid, distance, same_building, pair_id, fresh_sample,
                    input ready);
    modport sink   (input valid, distance, same_building, pair_id, fresh_sample,
                    output ready);
endinterface

interface ipl_result_if;
    logic                          valid;
    logic                          ready;
    logic [ipl_pkg::LOSS_W-1:0]    loss_db;
    logic                          line_of_sight;

    modport source (output valid, loss_db, line_of_sight, input ready);
    modport sink   (input valid, loss_db, line_of_sight, output ready);
endinterface

interface ipl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ipl_pkg::CARRIER_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hdl/ipl_mul.sv
// ----------------------------------------------------------------------------
// ipl_mul: shared signed multiplier
// 33x33 signed product, registered, low 64 bits kept. One result per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipl_mul (
    input  logic                                clk,
    input  logic signed [ipl_pkg::MUL_W-1:0]    a,
    input  logic signed [ipl_pkg::MUL_W-1:0]    b,
    output logic signed [ipl_pkg::PROD_W-1:0]   p
);

    logic signed [2*ipl_pkg::MUL_W-1:0] full;
    logic signed [ipl_pkg::PROD_W-1:0]  p_reg;

    assign full = a * b;
    assign p    = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= $signed(full[ipl_pkg::PROD_W-1:0]);
    end

endmodule

`default_nettype wire

// File: hdl/ipl_cache.sv
// ----------------------------------------------------------------------------
// ipl_cache: per-pair sample store
// Valid and sample memories on one address, registered read, clear of valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ipl_cache #(
    parameter int PAIRS       = ipl_pkg::PAIRS_DEF,
    parameter int SAMPLE_BITS = ipl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  ipl_pkg::cache_ctl_t         ctl,
    input  logic [$clog2(PAIRS)-1:0]    addr,
    input  logic [SAMPLE_BITS-1:0]      wr_sample,
    output logic                        rd_valid,
    output logic [SAMPLE_BITS-1:0]      rd_sample
);

    logic                   valid_mem  [PAIRS];
    logic [SAMPLE_BITS-1:0] sample_mem [PAIRS];

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            valid_mem[addr] <= 1'b0;
        end
        else if (ctl.wr)
        begin
            valid_mem[addr]  <= 1'b1;
            sample_mem[addr] <= wr_sample;
        end
        if (ctl.rd)
        begin
            rd_valid  <= valid_mem[addr];
            rd_sample <= sample_mem[addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/indoor_path_loss_calculator_core.sv
// ----------------------------------------------------------------------------
// indoor_path_loss_calculator_core: indoor-to-indoor link path loss
// Sequencer around one shared multiplier; log2 by squaring, cached LOS samples.
// ----------------------------------------------------------------------------
// Usage:
//   link   : one transfer per link item (distance, same_building, pair_id,
//            fresh_sample). ready is high only while the block is idle.
//   result : one transfer per item (loss_db in 1/16 dB, line_of_sight).
//   cfg    : carrier_mhz write, taken only while idle; the block then
//            recomputes the frequency term when the carrier is in
//            758..798 MHz and goes straight back to idle otherwise.
//   Reset: valid marks of the pair store are cleared one entry per cycle,
//   then log2(16000) and the carrier term are computed before link ready
//   first rises.
//   A link item is taken only from idle, and the block returns to idle as
//   its result is loaded into the output register. A zero distance skips
//   the distance log2; a same-building item between the LOS bounds with a
//   nonzero sample first runs a log2 of the sample.
//   Each log2 runs 5 normalize steps, then 16 squarings on the shared
//   33x33 multiplier, each issued in S_LG_SQ and taken in S_LG_SQW.
//   A finished result waits in the output register; with the receiver
//   stalled the next item is still accepted and runs, then holds until the
//   output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module indoor_path_loss_calculator_core #(
    parameter int PAIRS       = ipl_pkg::PAIRS_DEF,
    parameter int SAMPLE_BITS = ipl_pkg::SAMPLE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    ipl_link_if.sink        link,
    ipl_result_if.source    result,
    ipl_cfg_if.sink         cfg
);

    localparam int IDX_W = $clog2(PAIRS);
    localparam logic [SAMPLE_BITS:0] R_HALF = (SAMPLE_BITS + 1)'(1) << (SAMPLE_BITS - 1);
    localparam logic [ipl_pkg::DLOG_W-1:0] SB_Q16 =
        ipl_pkg::DLOG_W'(SAMPLE_BITS) << 16;

    typedef enum logic [4:0] {
        S_CLR, S_REFD, S_FSTART, S_FM1, S_FM2, S_FM3, S_IDLE, S_CHK,
        S_LS1, S_LS2, S_LS3, S_DIST, S_F1, S_F2, S_F3, S_F4, S_F5,
        S_FT, S_RND, S_DIV, S_DONE, S_LG_NORM, S_LG_SQ, S_LG_SQW
    } state_t;

    typedef enum logic [1:0] {
        LT_REF, LT_FREQ, LT_SAMP, LT_DIST
    } log_tgt_t;

    // control
    state_t                             state_reg, state_next;
    log_tgt_t                           tgt_reg, tgt_next;
    logic [ipl_pkg::STEP_W-1:0]         lk_reg, lk_next;
    logic [IDX_W-1:0]                   clr_idx_reg, clr_idx_next;
    logic [ipl_pkg::CARRIER_W-1:0]      carrier_reg, carrier_next;
    logic                               out_valid_reg, out_valid_next;
    logic [ipl_pkg::LOSS_W-1:0]         loss_out_reg, loss_out_next;
    logic                               los_out_reg, los_out_next;

    // datapath
    logic [ipl_pkg::DIST_W-1:0]         d_reg, d_next;
    logic                               same_reg, same_next;
    logic [ipl_pkg::FRESH_W-1:0]        fresh_reg, fresh_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic                               los_reg, los_next;
    logic [ipl_pkg::LOG_ARG_W-1:0]      lv_reg, lv_next;
    logic [ipl_pkg::LOG_W-1:0]          lacc_reg, lacc_next;
    logic [ipl_pkg::LOG_W-1:0]          l16k_reg, l16k_next;
    logic [31:0]                        t_reg, t_next;
    logic signed [ipl_pkg::PROD_W-1:0]  x_reg, x_next;
    logic signed [ipl_pkg::PROD_W-1:0]  ft_reg, ft_next;
    logic [ipl_pkg::LOSS_W-1:0]         res_loss_reg, res_loss_next;

    // shared units
    logic signed [ipl_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [ipl_pkg::PROD_W-1:0]  mul_p;
    ipl_pkg::cache_ctl_t                cache_ctl;
    logic [IDX_W-1:0]                   cache_addr;
    logic                               cache_rd_valid;
    logic [SAMPLE_BITS-1:0]             cache_rd_sample;

    // log start request
    logic                               lg_start;
    logic [ipl_pkg::LOG_ARG_W-1:0]      lg_arg;
    log_tgt_t                           lg_tgt;

    logic [IDX_W-1:0]                   pair_map [ipl_pkg::PAIR_SPAN];
    logic [SAMPLE_BITS-1:0]             r_cur;
    logic signed [ipl_pkg::DLOG_W-1:0]  dlog_c, flog_c;
    logic [ipl_pkg::DLOG_W-1:0]         lhs_base;
    logic [ipl_pkg::MUL_W-1:0]          sq;
    logic                               fen;
    logic signed [ipl_pkg::PROD_W-1:0]  a1_q48, x2, y;
    logic signed [ipl_pkg::MUL_W-1:0]   b1;
    logic [15:0]                        quo;
    logic                               link_ready, cfg_ready;

    for (genvar g = 0; g < ipl_pkg::PAIR_SPAN; g++)
    begin : g_pair_map
        assign pair_map[g] = IDX_W'(g % PAIRS);
    end

    ipl_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ipl_cache #(
        .PAIRS       (PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cache (
        .clk       (clk),
        .ctl       (cache_ctl),
        .addr      (cache_addr),
        .wr_sample (SAMPLE_BITS'(fresh_reg)),
        .rd_valid  (cache_rd_valid),
        .rd_sample (cache_rd_sample)
    );

    assign r_cur    = cache_rd_valid ? cache_rd_sample : SAMPLE_BITS'(fresh_reg);
    assign dlog_c   = $signed({1'b0, lacc_reg}) - $signed({1'b0, l16k_reg});
    assign flog_c   = dlog_c + ipl_pkg::OCTAVE3;
    assign lhs_base = SB_Q16 - {1'b0, lacc_reg};
    assign sq       = mul_p[ipl_pkg::PROD_W-1:31];
    assign fen      = (carrier_reg >= ipl_pkg::FREQ_LO) && (carrier_reg <= ipl_pkg::FREQ_HI);
    assign a1_q48   = !same_reg ? ipl_pkg::A_DB1 : (los_reg ? ipl_pkg::A_LOS : ipl_pkg::A_NLOS);
    assign b1       = !same_reg ? ipl_pkg::B_DB1 : (los_reg ? ipl_pkg::B_LOS : ipl_pkg::B_NLOS);
    assign x2       = ipl_pkg::A_DB2 + mul_p;
    assign y        = x_reg + ipl_pkg::ROUND_HALF;
    assign quo      = mul_p[33:18];

    assign link.ready    = link_ready;
    assign cfg.ready     = cfg_ready;
    assign result.valid  = out_valid_reg;
    assign result.loss_db       = loss_out_reg;
    assign result.line_of_sight = los_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        tgt_next       = tgt_reg;
        lk_next        = lk_reg;
        clr_idx_next   = clr_idx_reg;
        carrier_next   = carrier_reg;
        out_valid_next = out_valid_reg;
        loss_out_next  = loss_out_reg;
        los_out_next   = los_out_reg;
        d_next         = d_reg;
        same_next      = same_reg;
        fresh_next     = fresh_reg;
        idx_next       = idx_reg;
        los_next       = los_reg;
        lv_next        = lv_reg;
        lacc_next      = lacc_reg;
        l16k_next      = l16k_reg;
        t_next         = t_reg;
        x_next         = x_reg;
        ft_next        = ft_reg;
        res_loss_next  = res_loss_reg;
        mul_a          = '0;
        mul_b          = '0;
        cache_ctl      = '0;
        cache_addr     = idx_reg;
        lg_start       = 1'b0;
        lg_arg         = '0;
        lg_tgt         = LT_REF;
        link_ready     = 1'b0;
        cfg_ready      = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                cache_ctl.clr = 1'b1;
                cache_addr    = clr_idx_reg;
                if (clr_idx_reg == IDX_W'(PAIRS - 1))
                begin
                    lg_start = 1'b1;
                    lg_arg   = ipl_pkg::REF_DIST;
                    lg_tgt   = LT_REF;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            S_REFD:
            begin
                l16k_next  = lacc_reg;
                state_next = S_FSTART;
            end
            S_FSTART:
            begin
                if (fen)
                begin
                    lg_start = 1'b1;
                    lg_arg   = ipl_pkg::LOG_ARG_W'(carrier_reg);
                    lg_tgt   = LT_FREQ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FM1:
            begin
                mul_a      = ipl_pkg::MUL_W'(flog_c);
                mul_b      = ipl_pkg::FREQ_SCALE;
                state_next = S_FM2;
            end
            S_FM2:
            begin
                mul_a      = $signed(mul_p[ipl_pkg::MUL_W-1:0]);
                mul_b      = ipl_pkg::LOG10_2_Q32;
                state_next = S_FM3;
            end
            S_FM3:
            begin
                ft_next    = mul_p;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cfg_ready  = 1'b1;
                link_ready = !cfg.valid;
                if (cfg.valid)
                begin
                    carrier_next = cfg.data;
                    state_next   = S_FSTART;
                end
                else if (link.valid)
                begin
                    d_next        = link.distance;
                    same_next     = link.same_building;
                    fresh_next    = link.fresh_sample;
                    idx_next      = pair_map[link.pair_id];
                    los_next      = 1'b0;
                    cache_ctl.rd  = link.same_building;
                    cache_addr    = pair_map[link.pair_id];
                    state_next    = link.same_building ? S_CHK : S_DIST;
                end
            end
            S_CHK:
            begin
                cache_ctl.wr = !cache_rd_valid;
                state_next   = S_DIST;
                if (d_reg <= ipl_pkg::LOS_NEAR)
                begin
                    los_next = 1'b1;
                end
                else if (d_reg < ipl_pkg::LOS_FAR)
                begin
                    if (r_cur == '0)
                    begin
                        los_next = 1'b1;
                    end
                    else
                    begin
                        lg_start = 1'b1;
                        lg_arg   = ipl_pkg::LOG_ARG_W'(r_cur);
                        lg_tgt   = LT_SAMP;
                    end
                end
                else
                begin
                    los_next = ({1'b0, r_cur} <= R_HALF);
                end
            end
            S_LS1:
            begin
                mul_a      = ipl_pkg::MUL_W'(lhs_base);
                mul_b      = ipl_pkg::LOS_SLOPE;
                state_next = S_LS2;
            end
            S_LS2:
            begin
                t_next     = mul_p[31:0];
                mul_a      = ipl_pkg::MUL_W'(d_reg - ipl_pkg::LOS_NEAR);
                mul_b      = ipl_pkg::LOG2E_Q16;
                state_next = S_LS3;
            end
            S_LS3:
            begin
                los_next   = (t_reg >= mul_p[31:0]);
                state_next = S_DIST;
            end
            S_DIST:
            begin
                if (d_reg == '0)
                begin
                    res_loss_next = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    lg_start = 1'b1;
                    lg_arg   = ipl_pkg::LOG_ARG_W'(d_reg);
                    lg_tgt   = LT_DIST;
                end
            end
            S_F1:
            begin
                mul_a      = ipl_pkg::MUL_W'(dlog_c);
                mul_b      = b1;
                state_next = S_F2;
            end
            S_F2:
            begin
                mul_a      = $signed(mul_p[ipl_pkg::MUL_W-1:0]);
                mul_b      = ipl_pkg::LOG10_2_Q32;
                state_next = S_F3;
            end
            S_F3:
            begin
                x_next = a1_q48 + mul_p;
                if (same_reg)
                begin
                    state_next = S_FT;
                end
                else
                begin
                    mul_a      = ipl_pkg::MUL_W'(dlog_c);
                    mul_b      = ipl_pkg::B_DB2;
                    state_next = S_F4;
                end
            end
            S_F4:
            begin
                mul_a      = $signed(mul_p[ipl_pkg::MUL_W-1:0]);
                mul_b      = ipl_pkg::LOG10_2_Q32;
                state_next = S_F5;
            end
            S_F5:
            begin
                if (x2 > x_reg)
                begin
                    x_next = x2;
                end
                state_next = S_FT;
            end
            S_FT:
            begin
                if (fen)
                begin
                    x_next = x_reg + ft_reg;
                end
                state_next = S_RND;
            end
            S_RND:
            begin
                if (x_reg[ipl_pkg::PROD_W-1] || (x_reg == '0))
                begin
                    res_loss_next = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    mul_a      = ipl_pkg::MUL_W'(y[62:45]);
                    mul_b      = ipl_pkg::RECIP5;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                res_loss_next = (quo > ipl_pkg::LOSS_MAX) ? ipl_pkg::LOSS_MAX[ipl_pkg::LOSS_W-1:0]
                                                          : quo[ipl_pkg::LOSS_W-1:0];
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    loss_out_next  = res_loss_reg;
                    los_out_next   = same_reg && los_reg;
                    state_next     = S_IDLE;
                end
            end
            S_LG_NORM:
            begin
                unique case (lk_reg)
                    4'd0:
                        if (lv_reg[31:16] == '0)
                        begin
                            lv_next   = lv_reg << 16;
                            lacc_next = lacc_reg - (ipl_pkg::LOG_W'(16) << 16);
                        end
                    4'd1:
                        if (lv_reg[31:24] == '0)
                        begin
                            lv_next   = lv_reg << 8;
                            lacc_next = lacc_reg - (ipl_pkg::LOG_W'(8) << 16);
                        end
                    4'd2:
                        if (lv_reg[31:28] == '0)
                        begin
                            lv_next   = lv_reg << 4;
                            lacc_next = lacc_reg - (ipl_pkg::LOG_W'(4) << 16);
                        end
                    4'd3:
                        if (lv_reg[31:30] == '0)
                        begin
                            lv_next   = lv_reg << 2;
                            lacc_next = lacc_reg - (ipl_pkg::LOG_W'(2) << 16);
                        end
                    default:
                        if (!lv_reg[31])
                        begin
                            lv_next   = lv_reg << 1;
                            lacc_next = lacc_reg - (ipl_pkg::LOG_W'(1) << 16);
                        end
                endcase
                if (lk_reg == ipl_pkg::NORM_LAST)
                begin
                    lk_next    = ipl_pkg::SQ_FIRST;
                    state_next = S_LG_SQ;
                end
                else
                begin
                    lk_next = lk_reg + 1'b1;
                end
            end
            S_LG_SQ:
            begin
                mul_a      = $signed({1'b0, lv_reg});
                mul_b      = $signed({1'b0, lv_reg});
                state_next = S_LG_SQW;
            end
            S_LG_SQW:
            begin
                if (sq[ipl_pkg::MUL_W-1])
                begin
                    lv_next   = sq[ipl_pkg::MUL_W-1:1];
                    lacc_next = lacc_reg | (ipl_pkg::LOG_W'(1) << lk_reg);
                end
                else
                begin
                    lv_next = sq[ipl_pkg::LOG_ARG_W-1:0];
                end
                if (lk_reg == '0)
                begin
                    unique case (tgt_reg)
                        LT_REF:  state_next = S_REFD;
                        LT_FREQ: state_next = S_FM1;
                        LT_SAMP: state_next = S_LS1;
                        LT_DIST: state_next = S_F1;
                    endcase
                end
                else
                begin
                    lk_next    = lk_reg - 1'b1;
                    state_next = S_LG_SQ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (lg_start)
        begin
            lv_next    = lg_arg;
            lacc_next  = ipl_pkg::LOG_INIT;
            lk_next    = '0;
            tgt_next   = lg_tgt;
            state_next = S_LG_NORM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            tgt_reg       <= LT_REF;
            lk_reg        <= '0;
            clr_idx_reg   <= '0;
            carrier_reg   <= ipl_pkg::CARRIER_RESET;
            out_valid_reg <= 1'b0;
            loss_out_reg  <= '0;
            los_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tgt_reg       <= tgt_next;
            lk_reg        <= lk_next;
            clr_idx_reg   <= clr_idx_next;
            carrier_reg   <= carrier_next;
            out_valid_reg <= out_valid_next;
            loss_out_reg  <= loss_out_next;
            los_out_reg   <= los_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        same_reg     <= same_next;
        fresh_reg    <= fresh_next;
        idx_reg      <= idx_next;
        los_reg      <= los_next;
        lv_reg       <= lv_next;
        lacc_reg     <= lacc_next;
        l16k_reg     <= l16k_next;
        t_reg        <= t_next;
        x_reg        <= x_next;
        ft_reg       <= ft_next;
        res_loss_reg <= res_loss_next;
    end

endmodule

`default_nettype wire

// File: hdl/ipl_chk.sv
// ----------------------------------------------------------------------------
// ipl_chk: port checker for the path loss core
// Handshake and sequencing checks on the top-level channels, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module ipl_chk (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          link_valid,
    input  wire logic                          link_ready,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic                          res_valid,
    input  wire logic                          res_ready,
    input  wire logic [ipl_pkg::LOSS_W-1:0]    loss_db,
    input  wire logic                          line_of_sight
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(loss_db) && $stable(line_of_sight))
        else $error("result payload changed while stalled");

    a_cfg_first: assert property (@(posedge clk) disable iff (!rst_n)
        link_ready |-> !cfg_valid)
        else $error("link ready while a carrier write is pending");

    a_link_busy: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid && link_ready |=> !link_ready && !cfg_ready)
        else $error("ready right after a link transfer");

    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !link_ready)
        else $error("link ready right after a carrier write");

endmodule

bind indoor_path_loss_calculator_core ipl_chk u_ipl_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .link_valid    (link.valid),
    .link_ready    (link.ready),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .loss_db       (result.loss_db),
    .line_of_sight (result.line_of_sight)
);

`default_nettype wire
